/* rtl/bpc_pkg.sv */
// Shared types and constants for the barometric pressure compensation block.
// Used by bpc_wide_mul and barometric_pressure_compensation; depends on nothing.
`default_nettype none

package bpc_pkg;

  // Field widths
  localparam int unsigned CoeffW = 16;
  localparam int unsigned RawW   = 24;
  localparam int unsigned PresW  = 32;
  localparam int unsigned TempW  = 19;
  localparam int unsigned CfgIdxW = 3;

  // Corrected sensitivity width and the split point of the wide product
  localparam int unsigned SensW  = 42;
  localparam int unsigned SplitW = 21;
  localparam int unsigned ProdW  = 67;

  // Register stages from input beat to output beat
  localparam int unsigned NumStages = 13;

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [19:0] TempRef = 20'sd2000;
  localparam logic signed [19:0] TempLow = 20'sd1500;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSens     = 3'd0,
    CfgOff      = 3'd1,
    CfgTcs      = 3'd2,
    CfgTco      = 3'd3,
    CfgTref     = 3'd4,
    CfgTempsens = 3'd5,
    CfgSoEnable = 3'd6
  } bpc_cfg_e;

  // Load enables of the two stages of the wide multiplier
  typedef struct packed {
    logic pp_en;
    logic sum_en;
  } bpc_mul_en_t;

endpackage

`default_nettype wire

/* rtl/bpc_wide_mul.sv */
// Two-stage signed multiplier: 24-bit unsigned raw pressure times 42-bit signed sensitivity.
// Uses bpc_pkg for widths and the stage enable struct.
`default_nettype none

module bpc_wide_mul import bpc_pkg::*; (
  input  wire logic                      clk_i,
  input  wire bpc_mul_en_t               en_i,
  input  wire logic [RawW-1:0]           mcand_i,
  input  wire logic signed [SensW-1:0]   mplier_i,
  output logic signed [ProdW-1:0]        prod_o
);

  logic [SplitW-1:0]                 mplier_lo;
  logic signed [SensW-SplitW-1:0]    mplier_hi;
  logic [RawW+SplitW-1:0]            pp_lo_d, pp_lo_q;
  logic signed [RawW+SplitW:0]       pp_hi_d, pp_hi_q;
  logic signed [ProdW-1:0]           prod_d, prod_q;

  // Split the multiplier into an unsigned low half and a signed high half
  assign mplier_lo = mplier_i[SplitW-1:0];
  assign mplier_hi = mplier_i[SensW-1:SplitW];

  always_comb begin
    pp_lo_d = mcand_i * mplier_lo;
    pp_hi_d = $signed({1'b0, mcand_i}) * mplier_hi;
  end

  // Partial products
  always_ff @(posedge clk_i) begin
    if (en_i.pp_en) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
  end

  // Recombine: high partial weighted by the split point plus low partial
  assign prod_d = $signed({pp_hi_q, {SplitW{1'b0}}})
                + $signed({{(ProdW-RawW-SplitW){1'b0}}, pp_lo_q});

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/barometric_pressure_compensation.sv */
// Barometric pressure and temperature compensation, 13-stage pipeline.
// Depends on bpc_pkg and bpc_wide_mul.
//
// Usage:
//   Input channel: one beat carries a raw pressure conversion (24 bits) and a
//   raw temperature conversion (24 bits); it is taken when in_valid_i is high
//   and in_stall_o is low. Output channel: one beat carries the compensated
//   pressure (0.01 mbar, low 32 bits) and temperature (0.01 C, 19 bits); it
//   is taken when out_valid_o is high and out_stall_i is low.
//   Calibration words and the second-order enable are written through the
//   cfg port; the user must write them only while no beat is in flight,
//   as the block itself does not enforce this. One beat is accepted every
//   cycle while in_stall_o is low. The two 42-bit-by-24-bit product stages
//   and the 64-bit-class adders each own a stage, which sets the depth.
//   Reset empties the pipeline, clears the calibration words to zero and sets
//   the second-order enable.
//   When the receiver stalls, each stage holds only if the stage after it is
//   full and holding, so bubbles close up and the input keeps flowing until
//   every stage is occupied; then in_stall_o rises. Nothing is lost or repeated.
`default_nettype none

module barometric_pressure_compensation import bpc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [CoeffW-1:0]      cfg_data_i,
  // Input channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [RawW-1:0]        raw_pressure_i,
  input  wire logic [RawW-1:0]        raw_temperature_i,
  // Output channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [PresW-1:0]     pressure_o,
  output logic signed [TempW-1:0]     temperature_o
);

  // Calibration registers
  logic [CoeffW-1:0] c_sens_q, c_off_q, c_tcs_q, c_tco_q, c_tref_q, c_tempsens_q;
  logic              so_en_q;

  // Pipeline control
  logic [NumStages:1] v_q;
  logic [NumStages:1] adv;

  // Stage payloads
  logic [RawW-1:0]          d1_q [1:8];
  logic signed [25:0]       dt_d, dt_q;
  logic signed [42:0]       p_temp_d, p_temp_q, p_off_d, p_off_q, p_sens_d, p_sens_q;
  logic signed [51:0]       p_dtsq_d, p_dtsq_q;
  logic signed [42:0]       rt_temp, rt_off, rt_sens;
  logic signed [19:0]       tq_temp_d, tq_temp_q;
  logic signed [35:0]       tq_off_d, tq_off_q;
  logic signed [34:0]       tq_sens_d, tq_sens_q;
  logic [20:0]              t2_q [3:6];
  logic signed [19:0]       temp_d, temp_q [4:7];
  logic signed [36:0]       off_d, off_q [4:7];
  logic signed [35:0]       sens_d, sens_q [4:7];
  logic signed [19:0]       a_val, b_val;
  logic signed [39:0]       a_sq, b_sq;
  logic [35:0]              a2_q, b2_q;
  logic                     lt_ref_q [5:6];
  logic                     lt_low_q [5:6];
  logic [39:0]              a5, b7, b11;
  logic [39:0]              off2a_q, sens2a_q, off2b_q, sens2b_q;
  logic                     corr;
  logic [40:0]              off2_d, off2_q, sens2_d, sens2_q;
  logic [20:0]              t2g_d, t2g_q;
  logic signed [41:0]       off_f_d, off_f_q [8:11];
  logic signed [41:0]       sens_f_d, sens_f_q;
  logic signed [21:0]       temp_sub;
  logic [TempW-1:0]         temp_o_q [8:13];
  bpc_mul_en_t              mul_en;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  rt_prod;
  logic signed [45:0]       q_d, q_q;
  logic signed [46:0]       diff_d, diff_q;
  logic signed [46:0]       rt_diff;
  logic [PresW-1:0]         pres_d, pres_q;

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_sens_q     <= '0;
      c_off_q      <= '0;
      c_tcs_q      <= '0;
      c_tco_q      <= '0;
      c_tref_q     <= '0;
      c_tempsens_q <= '0;
      so_en_q      <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSens:     c_sens_q     <= cfg_data_i;
        CfgOff:      c_off_q      <= cfg_data_i;
        CfgTcs:      c_tcs_q      <= cfg_data_i;
        CfgTco:      c_tco_q      <= cfg_data_i;
        CfgTref:     c_tref_q     <= cfg_data_i;
        CfgTempsens: c_tempsens_q <= cfg_data_i;
        CfgSoEnable: so_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Advance: a stage loads when it is empty or its successor moves on
  always_comb begin
    adv[NumStages] = !v_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o  = !adv[1];
  assign out_valid_o = v_q[NumStages];

  // ---------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5 * 256
  assign dt_d = $signed({2'b00, raw_temperature_i}) - $signed({2'b00, c_tref_q, 8'h00});

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      dt_q     <= dt_d;
      d1_q[1]  <= raw_pressure_i;
    end
    // Carry raw pressure up to the wide multiplier
    for (int k = 2; k <= 8; k++) begin
      if (adv[k]) d1_q[k] <= d1_q[k-1];
    end
  end

  // Stage 2: products of dT
  always_comb begin
    p_temp_d = dt_q * $signed({1'b0, c_tempsens_q});
    p_off_d  = dt_q * $signed({1'b0, c_tco_q});
    p_sens_d = dt_q * $signed({1'b0, c_tcs_q});
    p_dtsq_d = dt_q * dt_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      p_temp_q <= p_temp_d;
      p_off_q  <= p_off_d;
      p_sens_q <= p_sens_d;
      p_dtsq_q <= p_dtsq_d;
    end
  end

  // Stage 3: truncating shifts (bias negative values toward zero)
  always_comb begin
    rt_temp   = p_temp_q + $signed({20'd0, {23{p_temp_q[42]}}});
    rt_off    = p_off_q  + $signed({36'd0, {7{p_off_q[42]}}});
    rt_sens   = p_sens_q + $signed({35'd0, {8{p_sens_q[42]}}});
    tq_temp_d = rt_temp[42:23];
    tq_off_d  = rt_off[42:7];
    tq_sens_d = rt_sens[42:8];
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      tq_temp_q <= tq_temp_d;
      tq_off_q  <= tq_off_d;
      tq_sens_q <= tq_sens_d;
      t2_q[3]   <= p_dtsq_q[51:31];
    end
    for (int k = 4; k <= 6; k++) begin
      if (adv[k]) t2_q[k] <= t2_q[k-1];
    end
  end

  // Stage 4: TEMP, OFF, SENS
  always_comb begin
    temp_d = tq_temp_q + TempRef;
    off_d  = $signed({5'd0, c_off_q, 16'd0}) + tq_off_q;
    sens_d = $signed({5'd0, c_sens_q, 15'd0}) + tq_sens_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      temp_q[4] <= temp_d;
      off_q[4]  <= off_d;
      sens_q[4] <= sens_d;
    end
    for (int k = 5; k <= 7; k++) begin
      if (adv[k]) begin
        temp_q[k] <= temp_q[k-1];
        off_q[k]  <= off_q[k-1];
        sens_q[k] <= sens_q[k-1];
      end
    end
  end

  // Stage 5: squared distances below the two thresholds
  always_comb begin
    a_val = temp_q[4] - TempRef;
    b_val = temp_q[4] + TempLow;
    a_sq  = a_val * a_val;
    b_sq  = b_val * b_val;
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      a2_q        <= a_sq[35:0];
      b2_q        <= b_sq[35:0];
      lt_ref_q[5] <= a_val[19];
      lt_low_q[5] <= b_val[19];
    end
    if (adv[6]) begin
      lt_ref_q[6] <= lt_ref_q[5];
      lt_low_q[6] <= lt_low_q[5];
    end
  end

  // Stage 6: constant scalings of the squares
  always_comb begin
    a5  = {4'd0, a2_q} + {2'd0, a2_q, 2'd0};
    b7  = {1'b0, b2_q, 3'd0} - {4'd0, b2_q};
    b11 = {1'b0, b2_q, 3'd0} + {3'd0, b2_q, 1'b0} + {4'd0, b2_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      off2a_q  <= {1'b0, a5[39:1]};
      sens2a_q <= {2'b00, a5[39:2]};
      off2b_q  <= b7;
      sens2b_q <= {1'b0, b11[39:1]};
    end
  end

  // Stage 7: total low-temperature corrections, zero when not applied
  assign corr = so_en_q && lt_ref_q[6];

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    t2g_d   = '0;
    if (corr) begin
      off2_d  = {1'b0, off2a_q}  + (lt_low_q[6] ? {1'b0, off2b_q}  : 41'd0);
      sens2_d = {1'b0, sens2a_q} + (lt_low_q[6] ? {1'b0, sens2b_q} : 41'd0);
      t2g_d   = t2_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
      t2g_q   <= t2g_d;
    end
  end

  // Stage 8: apply corrections
  always_comb begin
    off_f_d  = off_q[7]  - $signed({1'b0, off2_q});
    sens_f_d = sens_q[7] - $signed({1'b0, sens2_q});
    temp_sub = temp_q[7] - $signed({1'b0, t2g_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      off_f_q[8]  <= off_f_d;
      sens_f_q    <= sens_f_d;
      temp_o_q[8] <= temp_sub[TempW-1:0];
    end
    for (int k = 9; k <= 11; k++) begin
      if (adv[k]) off_f_q[k] <= off_f_q[k-1];
    end
    for (int k = 9; k <= 13; k++) begin
      if (adv[k]) temp_o_q[k] <= temp_o_q[k-1];
    end
  end

  // Stages 9 and 10: D1 * SENS
  assign mul_en.pp_en  = adv[9];
  assign mul_en.sum_en = adv[10];

  bpc_wide_mul u_mul (
    .clk_i    (clk_i),
    .en_i     (mul_en),
    .mcand_i  (d1_q[8]),
    .mplier_i (sens_f_q),
    .prod_o   (prod)
  );

  // Stage 11: product / 2^21 toward zero
  always_comb begin
    rt_prod = prod + $signed({46'd0, {21{prod[ProdW-1]}}});
    q_d     = rt_prod[ProdW-1:21];
  end

  always_ff @(posedge clk_i) begin
    if (adv[11]) q_q <= q_d;
  end

  // Stage 12: subtract offset
  assign diff_d = q_q - off_f_q[11];

  always_ff @(posedge clk_i) begin
    if (adv[12]) diff_q <= diff_d;
  end

  // Stage 13: / 2^15 toward zero, keep the low 32 bits
  always_comb begin
    rt_diff = diff_q + $signed({32'd0, {15{diff_q[46]}}});
    pres_d  = rt_diff[46:15];
  end

  always_ff @(posedge clk_i) begin
    if (adv[13]) pres_q <= pres_d;
  end

  assign pressure_o    = $signed(pres_q);
  assign temperature_o = $signed(temp_o_q[13]);

  // ---------------------------------------------------------------------------
  // Assertions

  // The input stalls only when the whole pipeline is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with a free stage");

  // An accepted input beat occupies the first stage
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[1])
    else $error("accepted beat missing from first stage");

  // A taken output beat with nothing behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[NumStages-1]) |=> !out_valid_o)
    else $error("output beat repeated");

endmodule

`default_nettype wire
